@@ sv/vpp_pkg.sv @@
`timescale 1ns / 1ps

package vpp_pkg;

    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;

    localparam int COORD_W = 32;
    localparam int TDATA_W = 3 * COORD_W;
    localparam int TUSER_W = 2;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    localparam int DIV_STEPS  = 32;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = DIV_STEPS / DIV_BITS;
    localparam int DIV_LAT    = DIV_STAGES + 3;
    localparam int PIPE_DEPTH = 6 + DIV_LAT + 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [15:0]        q214_t;

    localparam coord_t S32_MAX = 32'sh7FFF_FFFF;
    localparam coord_t S32_MIN = 32'sh8000_0000;

    localparam logic signed [32:0] CENTER_X = 33'((SCREEN_WIDTH / 2) * 65536);
    localparam logic signed [32:0] CENTER_Y = 33'((SCREEN_HEIGHT / 2) * 65536);

    localparam logic [2:0] REG_OFFSET_X  = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y  = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z  = 3'd2;
    localparam logic [2:0] REG_COS_YAW   = 3'd3;
    localparam logic [2:0] REG_SIN_YAW   = 3'd4;
    localparam logic [2:0] REG_COS_PITCH = 3'd5;
    localparam logic [2:0] REG_SIN_PITCH = 3'd6;
    localparam logic [2:0] REG_FOCAL     = 3'd7;

    localparam q214_t       RST_COS   = 16'sd16384;
    localparam logic [15:0] RST_FOCAL = 16'd200;

    function automatic coord_t sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? S32_MIN : S32_MAX;
        end
        return v[31:0];
    endfunction

    // round half up at bit 14, then clamp to 32 bits
    function automatic coord_t rnd14_sat(input logic signed [48:0] s);
        logic signed [49:0] t;
        logic        [35:0] sh;
        t  = 50'(s) + 50'sd8192;
        sh = t[49:14];
        if (!sh[35] && (|sh[34:31])) begin
            return S32_MAX;
        end
        if (sh[35] && !(&sh[34:31])) begin
            return S32_MIN;
        end
        return sh[31:0];
    endfunction

endpackage

@@ sv/vpp_div.sv @@
`timescale 1ns / 1ps

module vpp_div (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [48:0]     num_i,
    input  vpp_pkg::coord_t        den_i,
    output vpp_pkg::coord_t        quo_o
);
    import vpp_pkg::*;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
        logic [31:0] den;
        logic        neg;
        logic        ovf;
        logic        nz;
    } div_st_t;

    logic [46:0] pm_reg;
    logic [31:0] dm_reg;
    logic        neg_reg;
    logic        nz_reg;
    div_st_t     st_reg [DIV_STAGES+1];
    coord_t      quo_reg;

    logic [48:0] pm_full;
    logic [32:0] dm_full;
    div_st_t     st0;
    div_st_t     st_nx [DIV_STAGES];
    div_st_t     fin;

    always_comb begin
        pm_full = num_i[48] ? 49'(-num_i) : 49'(num_i);
        dm_full = den_i[31] ? 33'(-33'(den_i)) : 33'(den_i);
    end

    always_comb begin
        st0.rem = {1'b0, pm_reg[46:16]};
        st0.low = {pm_reg[15:0], 16'b0};
        st0.quo = '0;
        st0.den = dm_reg;
        st0.neg = neg_reg;
        st0.ovf = ({1'b0, pm_reg[46:16]} >= dm_reg);
        st0.nz  = nz_reg;
    end

    always_comb begin
        div_st_t     cur;
        logic [32:0] trial;
        for (int k = 0; k < DIV_STAGES; k++) begin
            cur = st_reg[k];
            for (int b = 0; b < DIV_BITS; b++) begin
                trial = {cur.rem, cur.low[31]};
                cur.low = {cur.low[30:0], 1'b0};
                if (trial >= {1'b0, cur.den}) begin
                    cur.rem = 32'(trial - {1'b0, cur.den});
                    cur.quo = {cur.quo[30:0], 1'b1};
                end else begin
                    cur.rem = trial[31:0];
                    cur.quo = {cur.quo[30:0], 1'b0};
                end
            end
            st_nx[k] = cur;
        end
    end

    assign fin = st_reg[DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            pm_reg     <= pm_full[46:0];
            dm_reg     <= dm_full[31:0];
            neg_reg    <= num_i[48] ^ den_i[31];
            nz_reg     <= (num_i != '0);
            st_reg[0]  <= st0;
            for (int k = 0; k < DIV_STAGES; k++) begin
                st_reg[k+1] <= st_nx[k];
            end
            if (!fin.nz) begin
                quo_reg <= '0;
            end else if (fin.ovf) begin
                quo_reg <= fin.neg ? S32_MIN : S32_MAX;
            end else if (fin.neg) begin
                quo_reg <= (fin.quo > 32'h8000_0000) ? S32_MIN : coord_t'(-fin.quo);
            end else begin
                quo_reg <= fin.quo[31] ? S32_MAX : coord_t'(fin.quo);
            end
        end
    end

    assign quo_o = quo_reg;

endmodule

@@ sv/vertex_perspective_projection.sv @@
`timescale 1ns / 1ps
// Throughput: one vertex per cycle while the skid entry is empty; the divider lanes
// retire two quotient bits per stage, and results leave through the output register.
// A two-entry output (register plus skid) drops s_tready only once both entries are full.
// Reset (aresetn low at a clock edge) empties the pipeline and loads the register defaults.

module vertex_perspective_projection (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [vpp_pkg::TDATA_W-1:0]    s_tdata,  // vertex_x, vertex_y, vertex_z
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vpp_pkg::TDATA_W-1:0]    m_tdata,  // screen_x, screen_y, depth
    output logic [vpp_pkg::TUSER_W-1:0]    m_tuser,  // in_front, zero_depth
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vpp_pkg::APB_AW-1:0]     paddr,
    input  logic [vpp_pkg::APB_DW-1:0]     pwdata,
    output logic [vpp_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import vpp_pkg::*;

    coord_t      off_x_reg, off_y_reg, off_z_reg;
    q214_t       cos_yaw_reg, sin_yaw_reg, cos_pitch_reg, sin_pitch_reg;
    logic [15:0] focal_reg;

    logic [2:0] reg_idx;
    logic       cfg_wr;

    coord_t vx, vy, vz;
    logic   en;

    coord_t             ax_reg, ay_reg, az_reg;
    logic signed [47:0] pxc_reg, pzs_reg, pxs_reg, pzc_reg;
    coord_t             ay2_reg;
    coord_t             x1_reg, z1_reg, ay3_reg;
    logic signed [47:0] pyc_reg, pzsp_reg, pys_reg, pzcp_reg;
    coord_t             x14_reg;
    coord_t             x15_reg, y1_reg, z2_reg;
    logic signed [48:0] fx_reg, fy_reg;
    coord_t             z26_reg;
    coord_t             dep_dly_reg [DIV_LAT];
    coord_t             sx_reg, sy_reg, dep_c_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;

    coord_t qx, qy;

    logic                m_valid_reg, skid_valid_reg;
    logic [TDATA_W-1:0]  m_data_reg, skid_data_reg;
    logic [TUSER_W-1:0]  m_user_reg, skid_user_reg;
    logic [TDATA_W-1:0]  fin_data;
    logic [TUSER_W-1:0]  fin_user;
    logic                fin_beat;

    // configuration port
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_x_reg     <= '0;
            off_y_reg     <= '0;
            off_z_reg     <= '0;
            cos_yaw_reg   <= RST_COS;
            sin_yaw_reg   <= '0;
            cos_pitch_reg <= RST_COS;
            sin_pitch_reg <= '0;
            focal_reg     <= RST_FOCAL;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_OFFSET_X:  off_x_reg     <= pwdata;
                REG_OFFSET_Y:  off_y_reg     <= pwdata;
                REG_OFFSET_Z:  off_z_reg     <= pwdata;
                REG_COS_YAW:   cos_yaw_reg   <= pwdata[15:0];
                REG_SIN_YAW:   sin_yaw_reg   <= pwdata[15:0];
                REG_COS_PITCH: cos_pitch_reg <= pwdata[15:0];
                REG_SIN_PITCH: sin_pitch_reg <= pwdata[15:0];
                REG_FOCAL:     focal_reg     <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_OFFSET_X:  prdata = off_x_reg;
            REG_OFFSET_Y:  prdata = off_y_reg;
            REG_OFFSET_Z:  prdata = off_z_reg;
            REG_COS_YAW:   prdata = {16'b0, cos_yaw_reg};
            REG_SIN_YAW:   prdata = {16'b0, sin_yaw_reg};
            REG_COS_PITCH: prdata = {16'b0, cos_pitch_reg};
            REG_SIN_PITCH: prdata = {16'b0, sin_pitch_reg};
            REG_FOCAL:     prdata = {16'b0, focal_reg};
            default:       prdata = '0;
        endcase
    end

    // datapath
    assign vx = s_tdata[COORD_W-1:0];
    assign vy = s_tdata[2*COORD_W-1:COORD_W];
    assign vz = s_tdata[3*COORD_W-1:2*COORD_W];

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg   <= sat33(33'(vx) + 33'(off_x_reg));
            ay_reg   <= sat33(33'(vy) + 33'(off_y_reg));
            az_reg   <= sat33(33'(vz) + 33'(off_z_reg));

            pxc_reg  <= ax_reg * cos_yaw_reg;
            pzs_reg  <= az_reg * sin_yaw_reg;
            pxs_reg  <= ax_reg * sin_yaw_reg;
            pzc_reg  <= az_reg * cos_yaw_reg;
            ay2_reg  <= ay_reg;

            x1_reg   <= rnd14_sat(49'(pxc_reg) - 49'(pzs_reg));
            z1_reg   <= rnd14_sat(49'(pxs_reg) + 49'(pzc_reg));
            ay3_reg  <= ay2_reg;

            pyc_reg  <= ay3_reg * cos_pitch_reg;
            pzsp_reg <= z1_reg * sin_pitch_reg;
            pys_reg  <= ay3_reg * sin_pitch_reg;
            pzcp_reg <= z1_reg * cos_pitch_reg;
            x14_reg  <= x1_reg;

            y1_reg   <= rnd14_sat(49'(pyc_reg) - 49'(pzsp_reg));
            z2_reg   <= rnd14_sat(49'(pys_reg) + 49'(pzcp_reg));
            x15_reg  <= x14_reg;

            fx_reg   <= x15_reg * $signed({1'b0, focal_reg});
            fy_reg   <= y1_reg * $signed({1'b0, focal_reg});
            z26_reg  <= z2_reg;

            dep_dly_reg[0] <= z26_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                dep_dly_reg[k] <= dep_dly_reg[k-1];
            end

            sx_reg    <= sat33(33'(qx) + CENTER_X);
            sy_reg    <= sat33(33'(qy) + CENTER_Y);
            dep_c_reg <= dep_dly_reg[DIV_LAT-1];
        end
    end

    vpp_div u_div_x (
        .aclk  (aclk),
        .en    (en),
        .num_i (fx_reg),
        .den_i (z26_reg),
        .quo_o (qx)
    );

    vpp_div u_div_y (
        .aclk  (aclk),
        .en    (en),
        .num_i (fy_reg),
        .den_i (z26_reg),
        .quo_o (qy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // output register and skid
    assign fin_data = {dep_c_reg, sy_reg, sx_reg};
    assign fin_user = {(dep_c_reg == '0), dep_c_reg[COORD_W-1]};
    assign fin_beat = en && vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg    <= fin_beat;
            end
        end else if (fin_beat) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
                m_user_reg <= skid_user_reg;
            end else if (fin_beat) begin
                m_data_reg <= fin_data;
                m_user_reg <= fin_user;
            end
        end else if (fin_beat) begin
            skid_data_reg <= fin_data;
            skid_user_reg <= fin_user;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds a beat while output is empty");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> vld_reg == $past(vld_reg))
        else $error("pipeline moved during stall");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("in_front and zero_depth both set");

    a_zero_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[3*COORD_W-1:2*COORD_W] == '0))
        else $error("zero_depth with nonzero depth");

endmodule

@@ tb/vertex_perspective_projection_tb.sv @@
`timescale 1ns / 1ps

module vertex_perspective_projection_tb;

    import vpp_pkg::*;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     DRAIN_CYCLES   = 40;
    localparam int     PRINT_CAP      = 40;
    localparam int     STREAM_PHASES  = 12;
    localparam int     PHASE_VERTICES = 130;
    localparam longint S32_HI         = 64'sd2147483647;
    localparam longint S32_LO         = -64'sd2147483648;

    typedef struct packed {
        coord_t screen_x;
        coord_t screen_y;
        coord_t depth;
        logic   in_front;
        logic   zero_depth;
    } proj_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;   // vertex_x, vertex_y, vertex_z
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;   // screen_x, screen_y, depth
    logic [TUSER_W-1:0]   m_tuser;   // in_front, zero_depth
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    logic [31:0]          cam_reg [8];
    proj_result_t         pending_proj [$];
    bit                   src_idle_en  = 1'b1;
    bit                   sink_idle_en = 1'b1;
    int                   mismatches      = 0;
    int                   vertices_sent   = 0;
    int                   results_checked = 0;
    int                   zero_depth_seen = 0;
    int                   in_front_seen   = 0;
    int                   reg_writes      = 0;

    vertex_perspective_projection dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic longint clamp32(input longint v);
        if (v > S32_HI) return S32_HI;
        if (v < S32_LO) return S32_LO;
        return v;
    endfunction

    function automatic longint rot_round(input longint p);
        return clamp32((p + 64'sd8192) >>> 14);
    endfunction

    function automatic longint persp_quot(input longint c, input longint z, input longint fl);
        longint num;
        num = c * fl * 64'sd65536;
        if (z == 0) begin
            if (num > 0) return S32_HI;
            if (num < 0) return S32_LO;
            return 0;
        end
        return clamp32(num / z);
    endfunction

    function automatic proj_result_t project_vertex(input coord_t vx, input coord_t vy,
                                                    input coord_t vz);
        proj_result_t r;
        longint ax, ay, az, cyw, syw, cpt, spt, fl, x1, z1, y1, z2;
        ax  = clamp32(longint'(vx) + longint'($signed(cam_reg[REG_OFFSET_X])));
        ay  = clamp32(longint'(vy) + longint'($signed(cam_reg[REG_OFFSET_Y])));
        az  = clamp32(longint'(vz) + longint'($signed(cam_reg[REG_OFFSET_Z])));
        cyw = longint'($signed(cam_reg[REG_COS_YAW][15:0]));
        syw = longint'($signed(cam_reg[REG_SIN_YAW][15:0]));
        cpt = longint'($signed(cam_reg[REG_COS_PITCH][15:0]));
        spt = longint'($signed(cam_reg[REG_SIN_PITCH][15:0]));
        fl  = longint'(cam_reg[REG_FOCAL][15:0]);
        x1  = rot_round(ax * cyw - az * syw);
        z1  = rot_round(ax * syw + az * cyw);
        y1  = rot_round(ay * cpt - z1 * spt);
        z2  = rot_round(ay * spt + z1 * cpt);
        r.screen_x   = coord_t'(clamp32(persp_quot(x1, z2, fl)
                                        + longint'(SCREEN_WIDTH / 2) * 64'sd65536));
        r.screen_y   = coord_t'(clamp32(persp_quot(y1, z2, fl)
                                        + longint'(SCREEN_HEIGHT / 2) * 64'sd65536));
        r.depth      = coord_t'(z2);
        r.in_front   = (z2 < 0);
        r.zero_depth = (z2 == 0);
        return r;
    endfunction

    function automatic logic [31:0] reg_width_mask(input logic [2:0] idx);
        return (idx <= REG_OFFSET_Z) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("[%0t] mismatch %s: got %h, want %h", $realtime, what, got, want);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        cam_reg[idx] = value & reg_width_mask(idx);
        reg_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic check_registers();
        logic [31:0] got;
        for (int i = 0; i < 8; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {3'(i), 2'b00};
            @(negedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready) @(posedge aclk);
            got = prdata;
            if ((got & reg_width_mask(3'(i))) != cam_reg[i]) begin
                report_mismatch($sformatf("register %0d readback", i),
                                got & reg_width_mask(3'(i)), cam_reg[i]);
            end
            @(negedge aclk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(negedge aclk);
        end
    endtask

    task automatic set_camera(input coord_t ox, input coord_t oy, input coord_t oz,
                              input q214_t cy, input q214_t sy, input q214_t cp,
                              input q214_t sp, input logic [15:0] fl);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_OFFSET_Z, oz);
        write_reg(REG_COS_YAW, {16'h0, cy});
        write_reg(REG_SIN_YAW, {16'h0, sy});
        write_reg(REG_COS_PITCH, {16'h0, cp});
        write_reg(REG_SIN_PITCH, {16'h0, sp});
        write_reg(REG_FOCAL, {16'h0, fl});
        check_registers();
    endtask

    task automatic send_vertex(input coord_t vx, input coord_t vy, input coord_t vz);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom(), $urandom(), $urandom()};
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vz, vy, vx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_proj.insert(pending_proj.size(), project_vertex(vx, vy, vz));
        vertices_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_proj.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic coord_t any_coord();
        case ($urandom_range(0, 7))
            0: return S32_MAX;
            1: return S32_MIN;
            default: return coord_t'($urandom());
        endcase
    endfunction

    function automatic coord_t near_coord();
        return coord_t'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
    endfunction

    function automatic q214_t trig_q214(input real a, input bit want_sin);
        real v;
        v = want_sin ? $sin(a) : $cos(a);
        return q214_t'($rtoi($floor(16384.0 * v + 0.5)));
    endfunction

    function automatic q214_t any_q214();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return q214_t'($urandom());
        endcase
    endfunction

    task automatic random_camera(input bit wild);
        real         yaw, pitch;
        logic [15:0] fl;
        if (wild) begin
            case ($urandom_range(0, 3))
                0: fl = 16'd0;
                1: fl = 16'hFFFF;
                default: fl = 16'($urandom());
            endcase
            set_camera(any_coord(), any_coord(), any_coord(), any_q214(), any_q214(),
                       any_q214(), any_q214(), fl);
        end else begin
            yaw   = $urandom_range(0, 6283) / 1000.0;
            pitch = $urandom_range(0, 6283) / 1000.0;
            set_camera(near_coord(), near_coord(), near_coord(),
                       trig_q214(yaw, 1'b0), trig_q214(yaw, 1'b1),
                       trig_q214(pitch, 1'b0), trig_q214(pitch, 1'b1),
                       16'($urandom_range(50, 1000)));
        end
    endtask

    task automatic send_random_vertex();
        coord_t vx, vy, vz;
        case ($urandom_range(0, 9))
            0: begin
                vx = any_coord();
                vy = any_coord();
                vz = any_coord();
            end
            1: begin
                vx = -$signed(cam_reg[REG_OFFSET_X]);
                vy = -$signed(cam_reg[REG_OFFSET_Y]);
                vz = -$signed(cam_reg[REG_OFFSET_Z]);
            end
            2: begin
                vx = near_coord();
                vy = near_coord();
                vz = -$signed(cam_reg[REG_OFFSET_Z]);
            end
            default: begin
                vx = near_coord();
                vy = near_coord();
                vz = near_coord();
            end
        endcase
        send_vertex(vx, vy, vz);
    endtask

    task automatic test_identity_camera();
        check_registers();
        send_vertex(32'sd0, 32'sd0, -32'sd65536);
        send_vertex(32'sd65536, -32'sd65536, -32'sd131072);
        send_vertex(-32'sd196608, 32'sd327680, -32'sd655360);
        send_vertex(32'sd65536, -32'sd65536, 32'sd0);
        send_vertex(-32'sd65536, 32'sd65536, 32'sd0);
        send_vertex(32'sd0, 32'sd0, 32'sd0);
        send_vertex(S32_MAX, S32_MAX, S32_MAX);
        send_vertex(S32_MIN, S32_MIN, S32_MIN);
        send_vertex(S32_MAX, S32_MIN, -32'sd1);
        send_vertex(S32_MIN, S32_MAX, 32'sd1);
        send_vertex(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
        send_vertex(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
        wait_idle();
    endtask

    task automatic test_offset_saturation();
        set_camera(S32_MAX, S32_MAX, S32_MIN, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
                   16'd200);
        send_vertex(S32_MAX, 32'sd1, -32'sd1);
        wait_idle();
        set_camera(S32_MIN, S32_MIN, S32_MAX, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
                   16'd200);
        send_vertex(S32_MIN, -32'sd1, 32'sd1);
        wait_idle();
    endtask

    task automatic test_rotation_corners();
        set_camera(32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd16384, 16'sd0, -16'sd16384,
                   16'd200);
        send_vertex(32'sd65536, 32'sd131072, -32'sd327680);
        send_vertex(-32'sd655360, 32'sd65536, 32'sd65536);
        wait_idle();
        set_camera(32'sd0, 32'sd0, 32'sd0, -16'sd16384, 16'sd0, -16'sd16384, 16'sd0,
                   16'd200);
        send_vertex(32'sd65536, -32'sd131072, 32'sd327680);
        wait_idle();
        set_camera(32'sd0, 32'sd0, 32'sd0, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                   16'd200);
        send_vertex(S32_MAX, S32_MIN, S32_MAX);
        send_vertex(32'sd65536, 32'sd65536, -32'sd65536);
        wait_idle();
    endtask

    task automatic test_focal_extremes();
        set_camera(32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'd0);
        send_vertex(S32_MAX, S32_MIN, -32'sd65536);
        send_vertex(32'sd65536, -32'sd65536, 32'sd0);
        wait_idle();
        set_camera(32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'd1);
        send_vertex(32'sd65536, -32'sd65536, 32'sd1);
        send_vertex(S32_MAX, S32_MIN, -32'sd65536);
        wait_idle();
        set_camera(32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
                   16'hFFFF);
        send_vertex(S32_MIN, S32_MAX, 32'sd1);
        send_vertex(32'sd65536, -32'sd65536, -32'sd655360);
        wait_idle();
    endtask

    task automatic test_random_stream();
        for (int p = 0; p < STREAM_PHASES; p++) begin
            src_idle_en  = (p < STREAM_PHASES - 2) && (p % 4 != 1);
            sink_idle_en = (p < STREAM_PHASES - 2) && (p % 4 != 2);
            random_camera(p % 3 == 2);
            for (int n = 0; n < PHASE_VERTICES; n++) begin
                send_random_vertex();
            end
            wait_idle();
        end
    endtask

    always @(posedge aclk) begin
        proj_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_proj.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata[31:0], 32'h0);
            end else begin
                want = pending_proj.pop_front();
                results_checked++;
                if (want.zero_depth) zero_depth_seen++;
                if (want.in_front) in_front_seen++;
                if (m_tdata[31:0] !== want.screen_x) begin
                    report_mismatch("screen_x", m_tdata[31:0], want.screen_x);
                end
                if (m_tdata[63:32] !== want.screen_y) begin
                    report_mismatch("screen_y", m_tdata[63:32], want.screen_y);
                end
                if (m_tdata[95:64] !== want.depth) begin
                    report_mismatch("depth", m_tdata[95:64], want.depth);
                end
                if (m_tuser[0] !== want.in_front) begin
                    report_mismatch("in_front", {31'h0, m_tuser[0]}, {31'h0, want.in_front});
                end
                if (m_tuser[1] !== want.zero_depth) begin
                    report_mismatch("zero_depth", {31'h0, m_tuser[1]},
                                    {31'h0, want.zero_depth});
                end
            end
        end
    end

    initial begin : result_sink
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                stall--;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                stall    = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("vertex_perspective_projection regression: fail");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cam_reg[REG_OFFSET_X]  = 32'h0;
        cam_reg[REG_OFFSET_Y]  = 32'h0;
        cam_reg[REG_OFFSET_Z]  = 32'h0;
        cam_reg[REG_COS_YAW]   = 32'd16384;
        cam_reg[REG_SIN_YAW]   = 32'h0;
        cam_reg[REG_COS_PITCH] = 32'd16384;
        cam_reg[REG_SIN_PITCH] = 32'h0;
        cam_reg[REG_FOCAL]     = 32'd200;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_identity_camera();
        test_offset_saturation();
        test_rotation_corners();
        test_focal_extremes();
        test_random_stream();
        wait_idle();

        $display("covered %0d vertices, %0d results checked, %0d register writes",
                 vertices_sent, results_checked, reg_writes);
        $display("results at zero depth: %0d, in front of camera: %0d, mismatches: %0d",
                 zero_depth_seen, in_front_seen, mismatches);
        if (mismatches == 0) begin
            $display("vertex_perspective_projection regression: pass");
        end else begin
            $display("vertex_perspective_projection regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/vpp_pkg.sv
sv/vpp_div.sv
sv/vertex_perspective_projection.sv
tb/vertex_perspective_projection_tb.sv
